>>> rtl/core/goci_pkg.sv
// Shared constants, payload types and address helper for the grid cost inflation block.
package goci_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);

    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int DIM_W  = 7;
    localparam int COST_W = 7;
    localparam int RAD_W  = 6;
    localparam int POS_W  = ROW_W + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_COST = 2'd2;

    localparam logic [DIM_W-1:0]  GRID_ROWS_RESET     = 7'd64;
    localparam logic [DIM_W-1:0]  GRID_COLS_RESET     = 7'd64;
    localparam logic [COST_W-1:0] OBSTACLE_COST_RESET = 7'd10;
    localparam logic [COST_W-1:0] MIN_COST            = 7'd4;

    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic             command;
        logic [ROW_W-1:0] cell_row;
        logic [COL_W-1:0] cell_col;
        logic             blocked;
    } in_item_t;

    typedef struct packed {
        logic [COST_W-1:0] cell_cost;
        logic              cell_movable;
        logic              out_of_grid;
    } out_item_t;

    typedef struct packed {
        logic              movable;
        logic [COST_W-1:0] cost;
    } cell_word_t;

    typedef struct packed {
        logic              start;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [RAD_W-1:0]  radius;
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  cols;
        logic [COST_W-1:0] cost;
    } walk_req_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [COST_W-1:0] value;
    } walk_step_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(int'(row) * MAX_COLS + int'(col));
    endfunction

endpackage

>>> rtl/core/grid_obstacle_cost_inflation_top.sv
// Grid cost map with obstacle inflation: control sequencer, configuration and cell store.
//
// Input transactions carry a command (scan or read), a cell row and column and a blocked
// flag; every input transaction yields exactly one output transaction with the cell's cost,
// its movable bit and an out-of-grid flag. Configuration registers (rows, columns,
// obstacle cost) are written through the plain write port; the user must write them only
// while the block is idle, which the block itself does not enforce. A read or an
// unblocked scan passes through the centre and result states; an out-of-grid command
// goes straight to the result state. A blocked scan with an obstacle cost of 6 or more
// walks the inflation window, one cell per cycle, through a read-modify-write on the
// single cell memory; it moves through the centre, walk and drain states before the result
// state. The window reaches R cells from its centre each way, with R = (obstacle_cost - 4) / 2.
// One command is worked on at a time; the next one is accepted as soon as the result has
// moved to the output register, even while the receiver is still stalling it.
// After reset the block sweeps the whole memory to zero, one cell per cycle, and holds
// in_stall high meanwhile; configuration writes are taken throughout.
// A stalled result is held unchanged in the output register until it is taken.
module grid_obstacle_cost_inflation_top
    import goci_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_CENTER = 6'b000100,
        ST_WALK   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DIM_W-1:0]  grid_rows_reg;
    logic [DIM_W-1:0]  grid_cols_reg;
    logic [COST_W-1:0] obstacle_cost_reg;

    logic [ADDR_W-1:0] clr_reg;
    in_item_t          cmd_reg;
    out_item_t         res_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;
    logic              p_valid_reg;
    logic [ADDR_W-1:0] p_addr_reg;
    logic [COST_W-1:0] p_value_reg;

    logic [DIM_W-1:0]  rows_eff;
    logic [DIM_W-1:0]  cols_eff;
    logic [RAD_W-1:0]  radius;
    logic              accept;
    logic              in_oog;
    logic              walk_go;
    logic              out_load;
    logic              clr_last;
    logic [ADDR_W-1:0] in_addr;
    logic [ADDR_W-1:0] center_addr;

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    cell_word_t        wr_word;
    cell_word_t        rd_word;
    cell_word_t        center_word;
    logic [$bits(cell_word_t)-1:0] rd_bits;

    walk_req_t         walk_req;
    walk_step_t        step;

    // Sizes above the store act as the store's own size.
    assign rows_eff = (int'(grid_rows_reg) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : grid_rows_reg;
    assign cols_eff = (int'(grid_cols_reg) > MAX_COLS) ? DIM_W'(MAX_COLS) : grid_cols_reg;
    assign radius   = (obstacle_cost_reg >= MIN_COST) ?
                      RAD_W'((obstacle_cost_reg - MIN_COST) >> 1) : '0;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_oog   = (DIM_W'(in_data.cell_row) >= rows_eff) ||
                      (DIM_W'(in_data.cell_col) >= cols_eff);
    assign in_addr     = cell_addr(in_data.cell_row, in_data.cell_col);
    assign center_addr = cell_addr(cmd_reg.cell_row, cmd_reg.cell_col);
    assign clr_last    = (clr_reg == ADDR_W'(DEPTH - 1));

    assign rd_word = cell_word_t'(rd_bits);

    // A blocked cell is overwritten with the obstacle cost rather than maximised.
    always_comb
    begin
        center_word = rd_word;
        if (cmd_reg.command == CMD_SCAN)
        begin
            center_word.movable = ~cmd_reg.blocked;
            if (cmd_reg.blocked)
            begin
                center_word.cost = obstacle_cost_reg;
            end
        end
    end

    assign walk_go = (cmd_reg.command == CMD_SCAN) && cmd_reg.blocked && (radius != '0);

    assign walk_req.start  = (state_reg == ST_CENTER) && walk_go;
    assign walk_req.row    = cmd_reg.cell_row;
    assign walk_req.col    = cmd_reg.cell_col;
    assign walk_req.radius = radius;
    assign walk_req.rows   = rows_eff;
    assign walk_req.cols   = cols_eff;
    assign walk_req.cost   = obstacle_cost_reg;

    assign out_load = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        mem_re     = 1'b0;
        rd_addr    = in_addr;
        mem_we     = 1'b0;
        wr_addr    = center_addr;
        wr_word    = center_word;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we  = 1'b1;
                wr_addr = clr_reg;
                wr_word = '0;
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mem_re     = 1'b1;
                    state_next = in_oog ? ST_RESULT : ST_CENTER;
                end
            end
            ST_CENTER:
            begin
                mem_we     = (cmd_reg.command == CMD_SCAN);
                state_next = walk_go ? ST_WALK : ST_RESULT;
            end
            ST_WALK:
            begin
                mem_re  = step.valid;
                rd_addr = step.addr;
                if (step.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        // Second half of the window read-modify-write: raise the cell if it is lower.
        if (p_valid_reg && (rd_word.cost < p_value_reg))
        begin
            mem_we       = 1'b1;
            wr_addr      = p_addr_reg;
            wr_word      = rd_word;
            wr_word.cost = p_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= (state_reg == ST_WALK) && step.valid;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg     <= GRID_ROWS_RESET;
            grid_cols_reg     <= GRID_COLS_RESET;
            obstacle_cost_reg <= OBSTACLE_COST_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_GRID_ROWS:     grid_rows_reg     <= DIM_W'(cfg_data);
                CFG_GRID_COLS:     grid_cols_reg     <= DIM_W'(cfg_data);
                CFG_OBSTACLE_COST: obstacle_cost_reg <= COST_W'(cfg_data);
                default:
                begin
                    grid_rows_reg <= grid_rows_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= in_data;
            res_reg <= '{cell_cost: '0, cell_movable: 1'b0, out_of_grid: 1'b1};
        end
        else if (state_reg == ST_CENTER)
        begin
            res_reg <= '{cell_cost: center_word.cost, cell_movable: center_word.movable,
                         out_of_grid: 1'b0};
        end
        if ((state_reg == ST_WALK) && step.valid)
        begin
            p_addr_reg  <= step.addr;
            p_value_reg <= step.value;
        end
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    goci_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (walk_req),
        .step  (step)
    );

    goci_ram #(
        .DEPTH (DEPTH),
        .WIDTH ($bits(cell_word_t))
    ) u_cell_ram (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .re      (mem_re),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    // An out-of-grid result carries no cost and no movable bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_of_grid |-> (out_data.cell_cost == '0) &&
                                              !out_data.cell_movable)
        else $error("out-of-grid result with non-zero payload");

    // Window writes only trail a walk; they never meet a new command.
    assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (state_reg == ST_WALK) || (state_reg == ST_DRAIN))
        else $error("window write outside the walk");

    // The walk never reads the cell that is being written back in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && mem_re |-> (wr_addr != rd_addr))
        else $error("read and write of the same cell in one cycle");

    // An accepted transaction always leaves the idle state on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted transaction not taken up");

endmodule

>>> rtl/core/goci_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module goci_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/goci_walker.sv
// Window walker: steps through the square inflation window one cell per cycle.
module goci_walker
    import goci_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  walk_req_t  req,
    output walk_step_t step
);

    logic                    active_reg;
    logic signed [POS_W-1:0] r_reg;
    logic signed [POS_W-1:0] c_reg;

    logic signed [POS_W-1:0] row_s;
    logic signed [POS_W-1:0] col_s;
    logic signed [POS_W-1:0] rad_s;
    logic signed [POS_W-1:0] rows_s;
    logic signed [POS_W-1:0] cols_s;
    logic signed [POS_W-1:0] dr;
    logic signed [POS_W-1:0] dc;
    logic signed [POS_W-1:0] dr_abs;
    logic signed [POS_W-1:0] dc_abs;
    logic signed [POS_W-1:0] cheb_dist;
    logic                    in_window;
    logic                    col_end;
    logic                    row_end;

    assign row_s  = signed'(POS_W'(req.row));
    assign col_s  = signed'(POS_W'(req.col));
    assign rad_s  = signed'(POS_W'(req.radius));
    assign rows_s = signed'(POS_W'(req.rows));
    assign cols_s = signed'(POS_W'(req.cols));

    assign dr        = r_reg - row_s;
    assign dc        = c_reg - col_s;
    assign dr_abs    = dr[POS_W-1] ? -dr : dr;
    assign dc_abs    = dc[POS_W-1] ? -dc : dc;
    assign cheb_dist = (dr_abs > dc_abs) ? dr_abs : dc_abs;

    // The centre itself is skipped, as are window cells beyond the grid edges.
    assign in_window = !r_reg[POS_W-1] && (r_reg < rows_s) &&
                       !c_reg[POS_W-1] && (c_reg < cols_s) &&
                       ((dr != '0) || (dc != '0));

    assign col_end = (c_reg == col_s + rad_s);
    assign row_end = (r_reg == row_s + rad_s);

    assign step.valid = active_reg && in_window;
    assign step.last  = active_reg && row_end && col_end;
    assign step.addr  = cell_addr(r_reg[ROW_W-1:0], c_reg[COL_W-1:0]);
    assign step.value = req.cost - COST_W'(2 * cheb_dist);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (req.start)
        begin
            active_reg <= 1'b1;
        end
        else if (step.last)
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            r_reg <= row_s - rad_s;
            c_reg <= col_s - rad_s;
        end
        else if (active_reg)
        begin
            if (col_end)
            begin
                c_reg <= col_s - rad_s;
                r_reg <= r_reg + POS_W'(1);
            end
            else
            begin
                c_reg <= c_reg + POS_W'(1);
            end
        end
    end

endmodule

>>> bench/tb_grid_obstacle_cost_inflation_top.sv
// Self-checking bench for the grid cost map with obstacle inflation.
module tb_grid_obstacle_cost_inflation_top
    import goci_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 42;

    // Keeps its own copy of the cost and movable maps and of the three registers, and
    // queues the report that each accepted command must produce.
    class cost_map_scoreboard;
        bit [COST_W-1:0] cost_map [DEPTH];
        bit              movable_map [DEPTH];
        int              rows_cfg;
        int              cols_cfg;
        int              cost_cfg;
        out_item_t       reports_due [$];
        int              errors;

        function new();
            foreach (cost_map[i])
            begin
                cost_map[i]    = '0;
                movable_map[i] = 1'b0;
            end
            rows_cfg = int'(GRID_ROWS_RESET);
            cols_cfg = int'(GRID_COLS_RESET);
            cost_cfg = int'(OBSTACLE_COST_RESET);
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_GRID_ROWS:     rows_cfg = int'(val);
                CFG_GRID_COLS:     cols_cfg = int'(val);
                CFG_OBSTACLE_COST: cost_cfg = int'(val);
                default: ;
            endcase
        endfunction

        // Raises every cell of the window around an obstacle, skipping cells off the grid.
        function void spread_cost(int row, int col, int rows, int cols);
            int radius;
            int dr;
            int dc;
            int d;
            int val;
            int addr;
            radius = (cost_cfg >= 4) ? (cost_cfg - 4) / 2 : 0;
            for (int r = row - radius; r <= row + radius; r++)
            begin
                if (r < 0 || r >= rows)
                    continue;
                for (int c = col - radius; c <= col + radius; c++)
                begin
                    if (c < 0 || c >= cols)
                        continue;
                    dr = (r > row) ? r - row : row - r;
                    dc = (c > col) ? c - col : col - c;
                    d  = (dr > dc) ? dr : dc;
                    if (d == 0)
                        continue;
                    val = cost_cfg - 2 * d;
                    if (val < int'(MIN_COST))
                        continue;
                    addr = r * MAX_COLS + c;
                    if (int'(cost_map[addr]) < val)
                        cost_map[addr] = val[COST_W-1:0];
                end
            end
        endfunction

        function void note_command(in_item_t it);
            int        rows;
            int        cols;
            int        addr;
            out_item_t rep;
            rows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
            cols = (cols_cfg > MAX_COLS) ? MAX_COLS : cols_cfg;
            if (int'(it.cell_row) >= rows || int'(it.cell_col) >= cols)
            begin
                rep.cell_cost    = '0;
                rep.cell_movable = 1'b0;
                rep.out_of_grid  = 1'b1;
            end
            else
            begin
                addr = int'(it.cell_row) * MAX_COLS + int'(it.cell_col);
                if (it.command == CMD_SCAN)
                begin
                    movable_map[addr] = !it.blocked;
                    if (it.blocked)
                    begin
                        // The obstacle itself is overwritten, not maximised.
                        cost_map[addr] = cost_cfg[COST_W-1:0];
                        spread_cost(int'(it.cell_row), int'(it.cell_col), rows, cols);
                    end
                end
                rep.cell_cost    = cost_map[addr];
                rep.cell_movable = movable_map[addr];
                rep.out_of_grid  = 1'b0;
            end
            reports_due.push_back(rep);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (reports_due.size() == 0)
            begin
                $display("%0t: unexpected result: cost %0d movable %0d out_of_grid %0d",
                         $time, got.cell_cost, got.cell_movable, got.out_of_grid);
                errors++;
                return;
            end
            want = reports_due.pop_front();
            if (got.cell_cost !== want.cell_cost)
            begin
                $display("%0t: cell_cost mismatch: expected %0d, actual %0d",
                         $time, want.cell_cost, got.cell_cost);
                errors++;
            end
            if (got.cell_movable !== want.cell_movable)
            begin
                $display("%0t: cell_movable mismatch: expected %0d, actual %0d",
                         $time, want.cell_movable, got.cell_movable);
                errors++;
            end
            if (got.out_of_grid !== want.out_of_grid)
            begin
                $display("%0t: out_of_grid mismatch: expected %0d, actual %0d",
                         $time, want.out_of_grid, got.out_of_grid);
                errors++;
            end
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    in_item_t              in_data      = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    out_item_t             out_data;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    cost_map_scoreboard board;
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int cur_rows  = int'(GRID_ROWS_RESET);
    int cur_cols  = int'(GRID_COLS_RESET);
    int cur_cost  = int'(OBSTACLE_COST_RESET);
    int last_row  = 32;
    int last_col  = 32;

    grid_obstacle_cost_inflation_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Random receiver back-pressure in bursts; stalls_on gates the start of each burst.
    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (burst > 0)
            begin
                out_stall <= 1'b1;
                burst--;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                burst = $urandom_range(0, 18);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_command(in_item_t it);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        board.note_command(it);
    endtask

    task automatic issue(logic cmd, int row, int col, logic blk);
        in_item_t it;
        it.command  = cmd;
        it.cell_row = ROW_W'(row);
        it.cell_col = COL_W'(col);
        it.blocked  = blk;
        send_command(it);
    endtask

    // Waits until every transaction has come back and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= CFG_DATA_W'(val);
        board.write_reg(idx, CFG_DATA_W'(val));
        @(posedge clk);
    endtask

    task automatic configure(int rows, int cols, int cost);
        put_reg(CFG_GRID_ROWS, rows);
        put_reg(CFG_GRID_COLS, cols);
        put_reg(CFG_OBSTACLE_COST, cost);
        cfg_write_en <= 1'b0;
        cur_rows = rows;
        cur_cols = cols;
        cur_cost = cost;
    endtask

    // Mostly inside the grid, often close to the latest obstacle, now and then anywhere.
    function automatic int pick_coord(int span, int centre, int reach);
        int v;
        if (span == 0 || $urandom_range(0, 6) == 0)
            return $urandom_range(0, 63);
        if ($urandom_range(0, 1) == 0)
        begin
            v = centre + int'($urandom_range(0, 2 * reach + 2)) - (reach + 1);
            if (v < 0)
                v = 0;
            if (v > 63)
                v = 63;
            return v;
        end
        return $urandom_range(0, span - 1);
    endfunction

    task automatic random_phase(int count);
        in_item_t it;
        int       span_r;
        int       span_c;
        int       reach;
        span_r = (cur_rows > MAX_ROWS) ? MAX_ROWS : cur_rows;
        span_c = (cur_cols > MAX_COLS) ? MAX_COLS : cur_cols;
        reach  = (cur_cost >= 4) ? (cur_cost - 4) / 2 : 0;
        repeat (count)
        begin
            it.command  = ($urandom_range(0, 1) == 0) ? CMD_SCAN : CMD_READ;
            it.blocked  = ($urandom_range(0, 9) < 4);
            it.cell_row = ROW_W'(pick_coord(span_r, last_row, reach));
            it.cell_col = COL_W'(pick_coord(span_c, last_col, reach));
            if (it.command == CMD_SCAN && it.blocked)
            begin
                last_row = int'(it.cell_row);
                last_col = int'(it.cell_col);
            end
            send_command(it);
        end
    endtask

    initial
    begin
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: cleared maps, 64 by 64 grid, obstacle cost 10.
        issue(CMD_READ, 0, 0, 1'b1);
        issue(CMD_READ, 63, 63, 1'b0);
        issue(CMD_SCAN, 0, 0, 1'b1);
        issue(CMD_READ, 1, 1, 1'b0);
        issue(CMD_READ, 3, 3, 1'b1);
        issue(CMD_READ, 4, 0, 1'b0);
        issue(CMD_SCAN, 63, 63, 1'b1);
        issue(CMD_READ, 60, 62, 1'b0);
        issue(CMD_SCAN, 32, 32, 1'b0);
        issue(CMD_SCAN, 33, 33, 1'b1);
        issue(CMD_READ, 32, 32, 1'b0);
        issue(CMD_SCAN, 33, 33, 1'b0);

        // A cost too small to inflate overwrites a higher cost; edges of a 40 by 40 grid.
        drain();
        configure(40, 40, 5);
        issue(CMD_SCAN, 33, 33, 1'b1);
        issue(CMD_READ, 34, 34, 1'b0);
        issue(CMD_SCAN, 40, 0, 1'b1);
        issue(CMD_READ, 0, 40, 1'b0);
        issue(CMD_READ, 39, 39, 1'b0);

        drain();
        configure(0, 127, 3);
        issue(CMD_SCAN, 0, 0, 1'b1);

        drain();
        configure(127, 1, 3);
        issue(CMD_SCAN, 63, 0, 1'b1);
        issue(CMD_READ, 5, 1, 1'b0);

        drain();
        configure(1, 64, 64);
        issue(CMD_SCAN, 0, 32, 1'b1);
        issue(CMD_READ, 0, 2, 1'b0);

        drain();
        configure(64, 64, 127);
        issue(CMD_SCAN, 10, 50, 1'b1);
        issue(CMD_READ, 63, 0, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            int rows;
            int cols;
            int cost;
            drain();
            case (p)
                0:
                begin
                    rows = 64; cols = 64; cost = 4;
                end
                1:
                begin
                    rows = 1; cols = 1; cost = 20;
                end
                2:
                begin
                    rows = 64; cols = 64; cost = 64;
                end
                PHASES - 1:
                begin
                    rows = 64; cols = 64; cost = 10;
                end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       rows = $urandom_range(65, 127);
                        1:       rows = $urandom_range(1, 4);
                        default: rows = $urandom_range(1, 64);
                    endcase
                    case ($urandom_range(0, 9))
                        0:       cols = $urandom_range(65, 127);
                        1:       cols = $urandom_range(1, 4);
                        default: cols = $urandom_range(1, 64);
                    endcase
                    cost = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                                       : $urandom_range(4, 24);
                end
            endcase
            // The last phase runs flat out on both sides.
            gaps_on   = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            stalls_on = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            configure(rows, cols, cost);
            random_phase(PHASE_ITEMS);
        end

        drain();
        if (board.errors == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/goci_pkg.sv
rtl/core/goci_ram.sv
rtl/core/goci_walker.sv
rtl/core/grid_obstacle_cost_inflation_top.sv
bench/tb_grid_obstacle_cost_inflation_top.sv
